@@ hw/rtl/ttv_pkg.sv @@
package ttv_pkg;

  // coordinate format
  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned FRAC_BITS   = 16;

  // delta, product and numerator widths
  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned NW = PW + 1;

  // stream payload widths, padded to whole bytes
  localparam int unsigned IN_FIELDS   = 5;
  localparam int unsigned IN_TDATA_W  = ((IN_FIELDS * COORD_WIDTH + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS  = 3;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELDS * COORD_WIDTH + 7) / 8) * 8;
  localparam int unsigned OUT_TUSER_W = 3;

  // triangle queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;

  // copy index of the final vertex of a triangle
  localparam logic [1:0] LAST_VERTEX = 2'd2;

  // edge deltas of one triangle, handed from front to back
  typedef struct packed {
    logic [2:0][DW-1:0] dp1;
    logic [2:0][DW-1:0] dp2;
    logic [DW-1:0]      du1;
    logic [DW-1:0]      dv1;
    logic [DW-1:0]      du2;
    logic [DW-1:0]      dv2;
  } job_t;

endpackage

@@ hw/rtl/ttv_front.sv @@
module ttv_front
  import ttv_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata_i,
  input  logic                  full_i,
  output logic                  push_o,
  output job_t                  job_o
);

  localparam logic [1:0] SLOT_FIRST  = 2'd0;
  localparam logic [1:0] SLOT_SECOND = 2'd1;
  localparam logic [1:0] SLOT_THIRD  = 2'd2;

  logic [1:0] slot_q, slot_d;
  logic       accept;

  logic [2:0][COORD_WIDTH-1:0] pos_in, pos0_q, pos1_q;
  logic [COORD_WIDTH-1:0]      u_in, v_in, u0_q, v0_q, u1_q, v1_q;

  function automatic logic [DW-1:0] delta(input logic [COORD_WIDTH-1:0] a,
                                          input logic [COORD_WIDTH-1:0] b);
    return {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
  endfunction

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pos_in[k] = s_axis_tdata_i[k*COORD_WIDTH +: COORD_WIDTH];
    end
    u_in = s_axis_tdata_i[3*COORD_WIDTH +: COORD_WIDTH];
    v_in = s_axis_tdata_i[4*COORD_WIDTH +: COORD_WIDTH];
  end

  // only the closing vertex needs room in the queue
  assign s_axis_tready_o = (slot_q != SLOT_THIRD) || !full_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign push_o          = accept && (slot_q == SLOT_THIRD);

  always_comb begin
    slot_d = slot_q;
    if (accept) begin
      unique case (slot_q)
        SLOT_FIRST:  slot_d = SLOT_SECOND;
        SLOT_SECOND: slot_d = SLOT_THIRD;
        default:     slot_d = SLOT_FIRST;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= SLOT_FIRST;
    end else begin
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && slot_q == SLOT_FIRST) begin
      pos0_q <= pos_in;
      u0_q   <= u_in;
      v0_q   <= v_in;
    end
    if (accept && slot_q == SLOT_SECOND) begin
      pos1_q <= pos_in;
      u1_q   <= u_in;
      v1_q   <= v_in;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      job_o.dp1[k] = delta(pos1_q[k], pos0_q[k]);
      job_o.dp2[k] = delta(pos_in[k], pos0_q[k]);
    end
    job_o.du1 = delta(u1_q, u0_q);
    job_o.dv1 = delta(v1_q, v0_q);
    job_o.du2 = delta(u_in, u0_q);
    job_o.dv2 = delta(v_in, v0_q);
  end

endmodule

@@ hw/rtl/ttv_fifo.sv @@
module ttv_fifo
  import ttv_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic empty_o
);

  localparam int unsigned PTRW = $clog2(FIFO_DEPTH);

  job_t            mem_q [FIFO_DEPTH];
  logic [PTRW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTRW:0]   count_q;

  function automatic logic [PTRW-1:0] bump(input logic [PTRW-1:0] p);
    return (p == PTRW'(FIFO_DEPTH - 1)) ? '0 : p + PTRW'(1);
  endfunction

  assign full_o  = (count_q == (PTRW+1)'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= bump(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= bump(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (PTRW+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (PTRW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ hw/rtl/ttv_div.sv @@
module ttv_div
  import ttv_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [NW-1:0]   num_i,
  input  logic signed [NW-1:0]   den_i,
  output logic                   done_o,
  output logic [COORD_WIDTH-1:0] quo_o
);

  // restoring division of |num| * 2^FRAC_BITS by |den|, one quotient bit a cycle
  localparam int unsigned DIVW  = NW + FRAC_BITS;
  localparam int unsigned CNTW  = $clog2(DIVW + 1);
  localparam int unsigned QW    = COORD_WIDTH + 1;

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [DIVW-1:0] n_q;
  logic [NW-1:0]   d_q;
  logic [NW:0]     rem_q, rem_sh;
  logic [QW-1:0]   q_q, lim, mag;
  logic            ovf_q, neg_q, ge;
  logic [NW-1:0]   num_mag, den_mag;

  assign num_mag = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
  assign den_mag = den_i[NW-1] ? NW'(-den_i) : NW'(den_i);

  assign rem_sh = {rem_q[NW-1:0], n_q[DIVW-1]};
  assign ge     = rem_sh >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNTW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(DIVW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= {num_mag, {FRAC_BITS{1'b0}}};
      d_q   <= den_mag;
      rem_q <= '0;
      q_q   <= '0;
      ovf_q <= 1'b0;
      neg_q <= num_i[NW-1] ^ den_i[NW-1];
    end else if (busy_q) begin
      n_q   <= n_q << 1;
      rem_q <= ge ? rem_sh - {1'b0, d_q} : rem_sh;
      q_q   <= {q_q[QW-2:0], ge};
      // any bit pushed past the top means the quotient is out of range
      ovf_q <= ovf_q | q_q[QW-1];
    end
  end

  // saturate the magnitude, then apply the sign
  assign lim    = neg_q ? (QW'(1) << (COORD_WIDTH - 1))
                        : (QW'(1) << (COORD_WIDTH - 1)) - QW'(1);
  assign mag    = (ovf_q || q_q > lim) ? lim : q_q;
  assign quo_o  = neg_q ? COORD_WIDTH'(-mag) : COORD_WIDTH'(mag);
  assign done_o = done_q;

endmodule

@@ hw/rtl/ttv_back.sv @@
module ttv_back
  import ttv_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   empty_i,
  input  job_t                   job_i,
  output logic                   pop_o,
  output logic                   div_start_o,
  output logic signed [NW-1:0]   div_num_o,
  output logic signed [NW-1:0]   div_den_o,
  input  logic                   div_done_i,
  input  logic [COORD_WIDTH-1:0] div_quo_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic [OUT_TUSER_W-1:0] m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MUL      = 3'd1;
  localparam logic [2:0] ST_DIV_GO   = 3'd2;
  localparam logic [2:0] ST_DIV_WAIT = 3'd3;
  localparam logic [2:0] ST_EMIT     = 3'd4;

  localparam int unsigned MUL_STEPS = 8;
  localparam int unsigned MSW       = $clog2(MUL_STEPS + 1);

  logic [2:0]     state_q, state_d;
  logic [MSW-1:0] mstep_q, prev_step;
  logic [1:0]     comp_q, emit_idx_q, pidx;
  job_t           job_q;

  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_d, prod_q, first_q;
  logic signed [NW-1:0] det_q, pair_diff;
  logic signed [NW-1:0] num_q [3];
  logic [COORD_WIDTH-1:0] tan_q [3];
  logic                 degen, load_out;

  logic                             m_valid_q;
  logic [OUT_FIELDS*COORD_WIDTH-1:0] m_data_q;
  logic [OUT_TUSER_W-1:0]           m_user_q;
  logic                             m_last_q;

  // det = du1*dv2 - dv1*du2, num_k = dp1_k*dv2 - dp2_k*dv1, one product a cycle
  always_comb begin
    case (mstep_q[2:0])
      3'd0:    begin mul_a = job_q.du1;    mul_b = job_q.dv2; end
      3'd1:    begin mul_a = job_q.dv1;    mul_b = job_q.du2; end
      3'd2:    begin mul_a = job_q.dp1[0]; mul_b = job_q.dv2; end
      3'd3:    begin mul_a = job_q.dp2[0]; mul_b = job_q.dv1; end
      3'd4:    begin mul_a = job_q.dp1[1]; mul_b = job_q.dv2; end
      3'd5:    begin mul_a = job_q.dp2[1]; mul_b = job_q.dv1; end
      3'd6:    begin mul_a = job_q.dp1[2]; mul_b = job_q.dv2; end
      default: begin mul_a = job_q.dp2[2]; mul_b = job_q.dv1; end
    endcase
  end

  assign prod_d    = mul_a * mul_b;
  assign prev_step = mstep_q - MSW'(1);
  assign pidx      = prev_step[2:1];
  assign pair_diff = NW'(first_q) - NW'(prod_q);

  assign degen       = (det_q == '0);
  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign div_start_o = (state_q == ST_DIV_GO) && !degen;
  assign div_num_o   = num_q[comp_q];
  assign div_den_o   = det_q;
  assign load_out    = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) state_d = ST_MUL;
      end
      ST_MUL: begin
        if (mstep_q == MSW'(MUL_STEPS)) state_d = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        if (!degen) state_d = ST_DIV_WAIT;
        else if (comp_q == LAST_VERTEX) state_d = ST_EMIT;
      end
      ST_DIV_WAIT: begin
        if (div_done_i) state_d = (comp_q == LAST_VERTEX) ? ST_EMIT : ST_DIV_GO;
      end
      ST_EMIT: begin
        if (load_out && emit_idx_q == LAST_VERTEX) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mstep_q    <= '0;
      comp_q     <= '0;
      emit_idx_q <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE) begin
        mstep_q <= '0;
      end else if (state_q == ST_MUL) begin
        mstep_q <= mstep_q + MSW'(1);
        comp_q  <= '0;
      end
      if ((state_q == ST_DIV_GO && degen) || (state_q == ST_DIV_WAIT && div_done_i)) begin
        comp_q <= comp_q + 2'd1;
      end
      if (state_q == ST_DIV_GO || state_q == ST_DIV_WAIT) begin
        emit_idx_q <= '0;
      end else if (load_out) begin
        emit_idx_q <= emit_idx_q + 2'd1;
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (state_q == ST_MUL) begin
      if (mstep_q != MSW'(MUL_STEPS)) begin
        prod_q <= prod_d;
      end
      if (mstep_q != '0) begin
        if (!prev_step[0]) begin
          first_q <= prod_q;
        end else begin
          case (pidx)
            2'd0:    det_q              <= pair_diff;
            default: num_q[pidx - 2'd1] <= pair_diff;
          endcase
        end
      end
    end
    if (state_q == ST_DIV_GO && degen) begin
      tan_q[comp_q] <= '0;
    end
    if (state_q == ST_DIV_WAIT && div_done_i) begin
      tan_q[comp_q] <= div_quo_i;
    end
    if (load_out) begin
      m_data_q <= {tan_q[2], tan_q[1], tan_q[0]};
      m_user_q <= {degen, emit_idx_q};
      m_last_q <= (emit_idx_q == LAST_VERTEX);
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(m_data_q);
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_user_q[2] |-> m_data_q == '0)
    else $error("degenerate triangle with nonzero tangent");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> m_last_q == (m_user_q[1:0] == LAST_VERTEX))
    else $error("last flag out of step with vertex index");

  a_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done_i |-> state_q == ST_DIV_WAIT)
    else $error("divider finished while no quotient expected");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_o |=> !div_done_i)
    else $error("divider result right after start");

endmodule

@@ hw/rtl/triangle_tangent_vector_unit.sv @@
// channel  | dir | handshake                     | payload
// s_axis   | in  | s_axis_tvalid_i/tready_o      | one vertex: pos xyz, tex uv, Q16.16
// m_axis   | out | m_axis_tvalid_o/tready_i      | tangent xyz, vertex index, degenerate
//
// a vertex is taken when offered, the third only while the two-entry triangle queue has room
// per triangle the back end pops the job, forms the products on the shared 33x33 multiplier,
//   runs the bit-serial divider (83 quotient bits) per tangent component, sends 3 copies out
// a degenerate triangle skips the divider; sink stalls hold up the copies
// reset clears the vertex counter, the queue and the back-end sequencer; no clearing pass
// the output register lets the back end finish a copy while the sink stalls
module triangle_tangent_vector_unit
  import ttv_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // pos_x, pos_y, pos_z, tex_u, tex_v
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // tangent_x, tangent_y, tangent_z
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // vertex_index, degenerate
  output logic [OUT_TUSER_W-1:0] m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  // front to queue
  logic push, full;
  job_t job_in;

  // queue to back
  logic pop, empty;
  job_t job_out;

  // back to divider
  logic                   div_start, div_done;
  logic signed [NW-1:0]   div_num, div_den;
  logic [COORD_WIDTH-1:0] div_quo;

  // collects vertices and forms edge deltas on the closing vertex
  ttv_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .full_i          (full),
    .push_o          (push),
    .job_o           (job_in)
  );

  // decouples vertex intake from the long arithmetic
  ttv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (job_out),
    .empty_o (empty)
  );

  // determinant, numerators, division sequencing and output copies
  ttv_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .job_i           (job_out),
    .pop_o           (pop),
    .div_start_o     (div_start),
    .div_num_o       (div_num),
    .div_den_o       (div_den),
    .div_done_i      (div_done),
    .div_quo_i       (div_quo),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // shared saturating fixed-point divider
  ttv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

endmodule
